@@ rtl/core/ftsp_pkg.sv @@
// Shared types, constants and helpers for the framed trace stream parser.
`default_nettype none

package ftsp_pkg;

	// Fixed layout of the file header.
	localparam int HeaderBytes = 16;

	// Depth of the token queue ahead of the output port.
	localparam int QueueDepth = 4;
	localparam int QueuePtrW  = $clog2(QueueDepth);
	localparam int QueueCntW  = $clog2(QueueDepth + 1);

	// Configuration port geometry and register indexes.
	localparam int CfgAddrW = 3;
	localparam logic REG_MAGIC   = 1'b0;
	localparam logic REG_VERSION = 1'b1;

	// Register values after reset.
	localparam logic [31:0] MagicReset   = 32'h5443_4150;
	localparam logic [15:0] VersionReset = 16'd2;

	// Input item types.
	localparam logic REQ_BYTE = 1'b0;
	localparam logic REQ_END  = 1'b1;

	// Error codes carried in an error token.
	localparam logic [63:0] ERR_SHORT_HEADER = 64'd0;
	localparam logic [63:0] ERR_BAD_MAGIC    = 64'd1;
	localparam logic [63:0] ERR_BAD_VERSION  = 64'd2;
	localparam logic [63:0] ERR_TRUNC_SIZE   = 64'd3;
	localparam logic [63:0] ERR_PAST_EOF     = 64'd4;
	localparam logic [63:0] ERR_TRUNC_BODY   = 64'd5;
	localparam logic [63:0] ERR_SIZE_DRIFT   = 64'd6;

	// Parser phase.
	typedef enum logic [3:0] {
		PH_HDR     = 4'd0,
		PH_FSIZE   = 4'd1,
		PH_TICK    = 4'd2,
		PH_ECOUNT  = 4'd3,
		PH_EIDX    = 4'd4,
		PH_EGEN    = 4'd5,
		PH_CCOUNT  = 4'd6,
		PH_CTAG    = 4'd7,
		PH_CLEN    = 4'd8,
		PH_CPAY    = 4'd9,
		PH_EVCOUNT = 4'd10,
		PH_EVLEN   = 4'd11,
		PH_EVBYTES = 4'd12,
		PH_DRAIN   = 4'd13,
		PH_STOP    = 4'd14
	} phase_t;

	// Token kinds.
	typedef enum logic [3:0] {
		KIND_TICK      = 4'd0,
		KIND_ENT_COUNT = 4'd1,
		KIND_INDEX     = 4'd2,
		KIND_GEN       = 4'd3,
		KIND_COMP_CNT  = 4'd4,
		KIND_TAG       = 4'd5,
		KIND_PAY_LEN   = 4'd6,
		KIND_PAY_BYTE  = 4'd7,
		KIND_EV_COUNT  = 4'd8,
		KIND_EV_LEN    = 4'd9,
		KIND_EV_BYTE   = 4'd10,
		KIND_FRAME_OK  = 4'd11,
		KIND_FILE_OK   = 4'd12,
		KIND_ERROR     = 4'd13
	} tok_kind_t;

	// One input transaction.
	typedef struct packed {
		logic       req_type;
		logic [7:0] data_byte;
	} in_item_t;

	// One output transaction.
	typedef struct packed {
		logic [3:0]  token_kind;
		logic [63:0] token_value;
		logic        last_of_run;
	} out_item_t;

	// Tokens produced by one parsed byte, handed to the queue.
	typedef struct packed {
		logic      first;
		logic      second;
		out_item_t tok0;
		out_item_t tok1;
	} push_t;

	// ORs a byte into one byte lane of the accumulator.
	function automatic logic [63:0] lane_or(input logic [63:0] acc, input logic [2:0] lane,
		input logic [7:0] b);
		logic [63:0] r;
		r = acc;
		for (int k = 0; k < 8; k++) begin
			if (lane == 3'(k)) begin
				r[8*k +: 8] = acc[8*k +: 8] | b;
			end
		end
		return r;
	endfunction

	// Byte width of the field collected in a phase.
	function automatic logic [3:0] field_width(input phase_t p);
		logic [3:0] w;
		case (p) inside
			PH_TICK: w = 4'd8;
			PH_FSIZE, PH_ECOUNT, PH_EIDX, PH_EGEN, PH_EVCOUNT, PH_EVLEN: w = 4'd4;
			PH_CTAG, PH_CLEN: w = 4'd2;
			default: w = 4'd1;
		endcase
		return w;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/framed_trace_stream_parser_unit.sv @@
// Top level of the framed trace stream parser: input register, parser, token queue, registers.
`default_nettype none

// The block takes one transaction per cycle while it does not stall: a file byte or an
// end-of-stream mark. A transaction waits in an input register, is parsed there in a
// single step, and its tokens (none, one or two) enter a four-entry queue that drives
// the token port; the first token is presented once its byte has been parsed into the
// queue. Byte intake stalls only while the queue holds more than two tokens, so the
// token port's one token per cycle, when the port does not stall, sets the sustained
// rate: a byte that yields two tokens (a zero event count, a zero event length or a
// last event byte that closes a frame) uses the token port twice. Every completed body
// field and frame end is reported as a token, as is a failed header check; after an
// error, bytes are dropped silently until end of stream restarts the parser.
// The magic word (offset 0) and version (offset 4) registers must be written only while
// the block is idle; the block itself does not enforce this.
module framed_trace_stream_parser_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	// Byte channel.
	input  wire logic                          byte_valid,
	output logic                               byte_stall,
	input  wire ftsp_pkg::in_item_t            byte_item,
	// Token channel.
	output logic                               token_valid,
	input  wire logic                          token_stall,
	output ftsp_pkg::out_item_t                token_item,
	// Configuration port.
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [ftsp_pkg::CfgAddrW-1:0] paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);

	logic               valid_s1;
	ftsp_pkg::in_item_t item_s1;
	logic               room;
	logic               go;
	logic               take_in;
	ftsp_pkg::push_t    push;
	logic [31:0]        magic_q;
	logic [15:0]        version_q;
	logic               cfg_wr;

	assign go         = valid_s1 && room;
	assign byte_stall = valid_s1 && !room;
	assign take_in    = byte_valid && !byte_stall;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (take_in) begin
			valid_s1 <= 1'b1;
		end else if (go) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take_in) begin
			item_s1 <= byte_item;
		end
	end

	// Configuration registers.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= ftsp_pkg::MagicReset;
			version_q <= ftsp_pkg::VersionReset;
		end else if (cfg_wr) begin
			unique case (paddr[ftsp_pkg::CfgAddrW-1])
				ftsp_pkg::REG_MAGIC:   magic_q   <= pwdata;
				ftsp_pkg::REG_VERSION: version_q <= pwdata[15:0];
				default: begin
				end
			endcase
		end
	end

	// Register readback.
	always_comb begin
		unique case (paddr[ftsp_pkg::CfgAddrW-1])
			ftsp_pkg::REG_MAGIC:   prdata = magic_q;
			ftsp_pkg::REG_VERSION: prdata = {16'd0, version_q};
			default:               prdata = '0;
		endcase
	end

	ftsp_parse u_parse (
		.clk              (clk),
		.arst_n           (arst_n),
		.go               (go),
		.item             (item_s1),
		.expected_magic   (magic_q),
		.expected_version (version_q),
		.push             (push)
	);

	ftsp_outq u_outq (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.room        (room),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item)
	);

endmodule

`default_nettype wire

@@ rtl/core/ftsp_parse.sv @@
// Parser state machine: consumes one byte or end of stream and produces up to two tokens.
`default_nettype none

module ftsp_parse (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             go,
	input  wire ftsp_pkg::in_item_t item,
	input  wire logic [31:0]      expected_magic,
	input  wire logic [15:0]      expected_version,
	output ftsp_pkg::push_t       push
);

	ftsp_pkg::phase_t phase_q, phase_n;
	logic [3:0]  fbi_q, fbi_n;
	logic [63:0] acc_q, acc_n;
	logic [1:0]  chk_q, chk_n;
	logic [31:0] frame_q, frame_n;
	logic        ovr_q, ovr_n;
	logic [31:0] ent_q, ent_n;
	logic [7:0]  comp_q, comp_n;
	logic [31:0] blob_q, blob_n;
	logic [31:0] ev_q, ev_n;

	// Field collection helpers.
	logic [63:0] acc_t;
	logic [3:0]  fbi_inc;
	logic        take_done;
	logic        use_take;
	logic [7:0]  b;

	// Emission and chained end-of-structure flags.
	logic                prim_v, sec_v;
	ftsp_pkg::tok_kind_t prim_kind, sec_kind;
	logic [63:0]         prim_val, sec_val;
	logic                end_comp, end_ent, end_evi, end_bdy;

	assign b         = item.data_byte;
	assign acc_t     = ftsp_pkg::lane_or(acc_q, fbi_q[2:0], b);
	assign fbi_inc   = fbi_q + 4'd1;
	assign take_done = (fbi_inc >= ftsp_pkg::field_width(phase_q));

	// State register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= ftsp_pkg::PH_HDR;
			fbi_q   <= '0;
			acc_q   <= '0;
			chk_q   <= 2'b11;
			frame_q <= '0;
			ovr_q   <= 1'b0;
			ent_q   <= '0;
			comp_q  <= '0;
			blob_q  <= '0;
			ev_q    <= '0;
		end else if (go) begin
			phase_q <= phase_n;
			fbi_q   <= fbi_n;
			acc_q   <= acc_n;
			chk_q   <= chk_n;
			frame_q <= frame_n;
			ovr_q   <= ovr_n;
			ent_q   <= ent_n;
			comp_q  <= comp_n;
			blob_q  <= blob_n;
			ev_q    <= ev_n;
		end
	end

	// Next state and tokens.
	always_comb begin
		phase_n   = phase_q;
		fbi_n     = fbi_q;
		acc_n     = acc_q;
		chk_n     = chk_q;
		frame_n   = frame_q;
		ovr_n     = ovr_q;
		ent_n     = ent_q;
		comp_n    = comp_q;
		blob_n    = blob_q;
		ev_n      = ev_q;
		prim_v    = 1'b0;
		prim_kind = ftsp_pkg::KIND_ERROR;
		prim_val  = '0;
		sec_v     = 1'b0;
		sec_kind  = ftsp_pkg::KIND_ERROR;
		sec_val   = '0;
		end_comp  = 1'b0;
		end_ent   = 1'b0;
		end_evi   = 1'b0;
		end_bdy   = 1'b0;
		use_take  = 1'b0;

		if (item.req_type == ftsp_pkg::REQ_END) begin
			// End of stream reports how the file ended, unless parsing had stopped on an error, then starts a new file.
			unique case (phase_q)
				ftsp_pkg::PH_STOP: begin
				end
				ftsp_pkg::PH_HDR: begin
					prim_v   = 1'b1;
					prim_val = ftsp_pkg::ERR_SHORT_HEADER;
				end
				ftsp_pkg::PH_FSIZE: begin
					prim_v = 1'b1;
					if (fbi_q == 4'd0) begin
						prim_kind = ftsp_pkg::KIND_FILE_OK;
					end else begin
						prim_val = ftsp_pkg::ERR_TRUNC_SIZE;
					end
				end
				default: begin
					prim_v   = 1'b1;
					prim_val = (frame_q != 32'd0) ? ftsp_pkg::ERR_PAST_EOF
						: ftsp_pkg::ERR_TRUNC_BODY;
				end
			endcase
			phase_n = ftsp_pkg::PH_HDR;
			fbi_n   = '0;
			acc_n   = '0;
			chk_n   = 2'b11;
			frame_n = '0;
			ovr_n   = 1'b0;
			ent_n   = '0;
			comp_n  = '0;
			blob_n  = '0;
			ev_n    = '0;
		end else begin
			// Body bytes count down the frame size or mark an overrun.
			if (phase_q != ftsp_pkg::PH_HDR && phase_q != ftsp_pkg::PH_FSIZE &&
					phase_q != ftsp_pkg::PH_DRAIN && phase_q != ftsp_pkg::PH_STOP) begin
				if (frame_q != 32'd0) begin
					frame_n = frame_q - 32'd1;
				end else begin
					ovr_n = 1'b1;
				end
			end

			unique case (phase_q)
				ftsp_pkg::PH_HDR: begin
					if (!fbi_q[3]) begin
						acc_n = acc_t;
					end
					if (fbi_q == 4'd3 && acc_n[31:0] != expected_magic) begin
						chk_n[0] = 1'b0;
					end
					if (fbi_q == 4'd5 && acc_n[47:32] != expected_version) begin
						chk_n[1] = 1'b0;
					end
					if (fbi_q == 4'(ftsp_pkg::HeaderBytes - 1)) begin
						fbi_n = '0;
						acc_n = '0;
						if (!chk_n[0]) begin
							prim_v   = 1'b1;
							prim_val = ftsp_pkg::ERR_BAD_MAGIC;
							phase_n  = ftsp_pkg::PH_STOP;
						end else if (!chk_n[1]) begin
							prim_v   = 1'b1;
							prim_val = ftsp_pkg::ERR_BAD_VERSION;
							phase_n  = ftsp_pkg::PH_STOP;
						end else begin
							phase_n = ftsp_pkg::PH_FSIZE;
						end
					end else begin
						fbi_n = fbi_inc;
					end
				end
				ftsp_pkg::PH_FSIZE: begin
					use_take = 1'b1;
					if (take_done) begin
						frame_n = acc_t[31:0];
						ovr_n   = 1'b0;
						phase_n = ftsp_pkg::PH_TICK;
					end
				end
				ftsp_pkg::PH_DRAIN: begin
					frame_n = frame_q - 32'd1;
					if (frame_q == 32'd1) begin
						prim_v   = 1'b1;
						prim_val = ftsp_pkg::ERR_SIZE_DRIFT;
						phase_n  = ftsp_pkg::PH_STOP;
					end
				end
				ftsp_pkg::PH_STOP: begin
				end
				ftsp_pkg::PH_TICK: begin
					use_take = 1'b1;
					if (take_done) begin
						prim_v    = 1'b1;
						prim_kind = ftsp_pkg::KIND_TICK;
						prim_val  = acc_t;
						phase_n   = ftsp_pkg::PH_ECOUNT;
					end
				end
				ftsp_pkg::PH_ECOUNT: begin
					use_take = 1'b1;
					if (take_done) begin
						prim_v    = 1'b1;
						prim_kind = ftsp_pkg::KIND_ENT_COUNT;
						prim_val  = acc_t;
						ent_n     = acc_t[31:0];
						phase_n   = (acc_t[31:0] != 32'd0) ? ftsp_pkg::PH_EIDX
							: ftsp_pkg::PH_EVCOUNT;
					end
				end
				ftsp_pkg::PH_EIDX: begin
					use_take = 1'b1;
					if (take_done) begin
						prim_v    = 1'b1;
						prim_kind = ftsp_pkg::KIND_INDEX;
						prim_val  = acc_t;
						phase_n   = ftsp_pkg::PH_EGEN;
					end
				end
				ftsp_pkg::PH_EGEN: begin
					use_take = 1'b1;
					if (take_done) begin
						prim_v    = 1'b1;
						prim_kind = ftsp_pkg::KIND_GEN;
						prim_val  = acc_t;
						phase_n   = ftsp_pkg::PH_CCOUNT;
					end
				end
				ftsp_pkg::PH_CCOUNT: begin
					use_take = 1'b1;
					if (take_done) begin
						prim_v    = 1'b1;
						prim_kind = ftsp_pkg::KIND_COMP_CNT;
						prim_val  = acc_t;
						comp_n    = acc_t[7:0];
						if (acc_t[7:0] == 8'd0) begin
							end_ent = 1'b1;
						end else begin
							phase_n = ftsp_pkg::PH_CTAG;
						end
					end
				end
				ftsp_pkg::PH_CTAG: begin
					use_take = 1'b1;
					if (take_done) begin
						prim_v    = 1'b1;
						prim_kind = ftsp_pkg::KIND_TAG;
						prim_val  = acc_t;
						phase_n   = ftsp_pkg::PH_CLEN;
					end
				end
				ftsp_pkg::PH_CLEN: begin
					use_take = 1'b1;
					if (take_done) begin
						prim_v    = 1'b1;
						prim_kind = ftsp_pkg::KIND_PAY_LEN;
						prim_val  = acc_t;
						blob_n    = {16'd0, acc_t[15:0]};
						if (acc_t[15:0] == 16'd0) begin
							end_comp = 1'b1;
						end else begin
							phase_n = ftsp_pkg::PH_CPAY;
						end
					end
				end
				ftsp_pkg::PH_CPAY: begin
					prim_v    = 1'b1;
					prim_kind = ftsp_pkg::KIND_PAY_BYTE;
					prim_val  = {56'd0, b};
					blob_n    = blob_q - 32'd1;
					end_comp  = (blob_q == 32'd1);
				end
				ftsp_pkg::PH_EVCOUNT: begin
					use_take = 1'b1;
					if (take_done) begin
						prim_v    = 1'b1;
						prim_kind = ftsp_pkg::KIND_EV_COUNT;
						prim_val  = acc_t;
						ev_n      = acc_t[31:0];
						if (acc_t[31:0] == 32'd0) begin
							end_bdy = 1'b1;
						end else begin
							phase_n = ftsp_pkg::PH_EVLEN;
						end
					end
				end
				ftsp_pkg::PH_EVLEN: begin
					use_take = 1'b1;
					if (take_done) begin
						prim_v    = 1'b1;
						prim_kind = ftsp_pkg::KIND_EV_LEN;
						prim_val  = acc_t;
						blob_n    = acc_t[31:0];
						if (acc_t[31:0] == 32'd0) begin
							end_evi = 1'b1;
						end else begin
							phase_n = ftsp_pkg::PH_EVBYTES;
						end
					end
				end
				ftsp_pkg::PH_EVBYTES: begin
					prim_v    = 1'b1;
					prim_kind = ftsp_pkg::KIND_EV_BYTE;
					prim_val  = {56'd0, b};
					blob_n    = blob_q - 32'd1;
					end_evi   = (blob_q == 32'd1);
				end
				default: begin
				end
			endcase

			// Field accumulator advances or clears when a field completes.
			if (use_take) begin
				acc_n = take_done ? '0 : acc_t;
				fbi_n = take_done ? '0 : fbi_inc;
			end

			// A finished component may finish its entity.
			if (end_comp) begin
				comp_n = comp_q - 8'd1;
				if (comp_q == 8'd1) begin
					end_ent = 1'b1;
				end else begin
					phase_n = ftsp_pkg::PH_CTAG;
				end
			end
			if (end_ent) begin
				ent_n   = ent_q - 32'd1;
				phase_n = (ent_q == 32'd1) ? ftsp_pkg::PH_EVCOUNT : ftsp_pkg::PH_EIDX;
			end

			// A finished event may finish the frame body.
			if (end_evi) begin
				ev_n = ev_q - 32'd1;
				if (ev_q == 32'd1) begin
					end_bdy = 1'b1;
				end else begin
					phase_n = ftsp_pkg::PH_EVLEN;
				end
			end

			// Body end: drain the rest of the frame, report drift, or close the frame.
			if (end_bdy) begin
				if (frame_n != 32'd0) begin
					phase_n = ftsp_pkg::PH_DRAIN;
				end else if (ovr_n) begin
					sec_v   = 1'b1;
					sec_val = ftsp_pkg::ERR_SIZE_DRIFT;
					phase_n = ftsp_pkg::PH_STOP;
				end else begin
					sec_v    = 1'b1;
					sec_kind = ftsp_pkg::KIND_FRAME_OK;
					phase_n  = ftsp_pkg::PH_FSIZE;
				end
			end
		end
	end

	// Pack the tokens in order; the last one closes the run.
	always_comb begin
		push.first             = go && (prim_v || sec_v);
		push.second            = go && prim_v && sec_v;
		push.tok0.token_kind   = prim_v ? prim_kind : sec_kind;
		push.tok0.token_value  = prim_v ? prim_val : sec_val;
		push.tok0.last_of_run  = !(prim_v && sec_v);
		push.tok1.token_kind   = sec_kind;
		push.tok1.token_value  = sec_val;
		push.tok1.last_of_run  = 1'b1;
	end

endmodule

`default_nettype wire

@@ rtl/core/ftsp_outq.sv @@
// Small token queue that takes up to two tokens a cycle and hands out one unless the token port stalls.
`default_nettype none

module ftsp_outq (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire ftsp_pkg::push_t push,
	output logic                room,
	output logic                token_valid,
	input  wire logic           token_stall,
	output ftsp_pkg::out_item_t token_item
);

	ftsp_pkg::out_item_t mem [ftsp_pkg::QueueDepth];

	logic [ftsp_pkg::QueuePtrW-1:0] wr_q, rd_q, wr_next;
	logic [ftsp_pkg::QueueCntW-1:0] cnt_q;
	logic [ftsp_pkg::QueueCntW-1:0] n_push;
	logic                           pop;

	assign wr_next     = wr_q + ftsp_pkg::QueuePtrW'(1);
	assign n_push      = ftsp_pkg::QueueCntW'(push.first) + ftsp_pkg::QueueCntW'(push.second);
	assign token_valid = (cnt_q != '0);
	assign pop         = token_valid && !token_stall;
	assign token_item  = mem[rd_q];
	// Room for the two tokens a byte can produce.
	assign room        = (cnt_q <= ftsp_pkg::QueueCntW'(ftsp_pkg::QueueDepth - 2));

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + ftsp_pkg::QueuePtrW'(n_push);
			rd_q  <= rd_q + ftsp_pkg::QueuePtrW'(pop);
			cnt_q <= cnt_q + n_push - ftsp_pkg::QueueCntW'(pop);
		end
	end

	// Token storage.
	always_ff @(posedge clk) begin
		if (push.first) begin
			mem[wr_q] <= push.tok0;
		end
		if (push.second) begin
			mem[wr_next] <= push.tok1;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/ftsp_checker.sv @@
// Port-level checks on the token channel of the parser, bound to the top level.
`default_nettype none

module ftsp_checker (
	input wire logic                 clk,
	input wire logic                 arst_n,
	input wire logic                 token_valid,
	input wire logic                 token_stall,
	input wire ftsp_pkg::out_item_t  token_item
);

	// A stalled token transaction stays put.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_stall |=> token_valid && $stable(token_item))
		else $error("stalled token changed or dropped");

	// Token kinds stop at the error kind.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid |-> token_item.token_kind <= ftsp_pkg::KIND_ERROR)
		else $error("token kind out of range");

	// Error tokens carry a known error code.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && token_item.token_kind == ftsp_pkg::KIND_ERROR
		|-> token_item.token_value <= ftsp_pkg::ERR_SIZE_DRIFT)
		else $error("unknown error code");

	// Frame, file and error tokens always close the run of their byte.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_item.token_kind == ftsp_pkg::KIND_FRAME_OK ||
		token_item.token_kind == ftsp_pkg::KIND_FILE_OK ||
		token_item.token_kind == ftsp_pkg::KIND_ERROR)
		|-> token_item.last_of_run)
		else $error("closing token not marked last");

	// Frame and file completion tokens carry a zero value.
	assert property (@(posedge clk) disable iff (!arst_n)
		token_valid && (token_item.token_kind == ftsp_pkg::KIND_FRAME_OK ||
		token_item.token_kind == ftsp_pkg::KIND_FILE_OK)
		|-> token_item.token_value == 64'd0)
		else $error("completion token with nonzero value");

endmodule

bind framed_trace_stream_parser_unit ftsp_checker u_ftsp_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.token_valid (token_valid),
	.token_stall (token_stall),
	.token_item  (token_item)
);

`default_nettype wire

@@ bench/framed_trace_stream_parser_unit_tb.sv @@
// Self-checking testbench for the framed trace stream parser: random trace files, token checks.
module framed_trace_stream_parser_unit_tb;

	// Cycles without any accepted transaction before the run is declared hung.
	localparam int QuietLimit = 2000;
	// Cycles allowed for the pipeline to empty after the last expected token.
	localparam int DrainCycles = 8;

	logic                          clk;
	logic                          arst_n = 1'b0;
	logic                          byte_valid = 1'b0;
	logic                          byte_stall;
	ftsp_pkg::in_item_t            byte_item = '0;
	logic                          token_valid;
	logic                          token_stall = 1'b0;
	ftsp_pkg::out_item_t           token_item;
	logic                          psel = 1'b0;
	logic                          penable = 1'b0;
	logic                          pwrite = 1'b0;
	logic [ftsp_pkg::CfgAddrW-1:0] paddr = '0;
	logic [31:0]                   pwdata = '0;
	logic [31:0]                   prdata;
	logic                          pready;

	// Stimulus and expectations.
	ftsp_pkg::in_item_t  pending_bytes [$];
	ftsp_pkg::out_item_t tokens_due [$];
	logic [7:0]          trace_bytes [$];
	int                  frame_starts [$];
	int                  gap_pct = 0;
	int                  stall_pct = 0;
	int                  mismatches = 0;
	int                  quiet_cycles = 0;
	int                  tokens_seen = 0;

	// Register values as the parser should see them.
	logic [31:0] cfg_magic = ftsp_pkg::MagicReset;
	logic [15:0] cfg_version = ftsp_pkg::VersionReset;

	// Parser state kept by the predictor.
	ftsp_pkg::phase_t    prs_phase;
	logic [3:0]          fld_idx;
	logic [63:0]         fld_acc;
	logic [1:0]          hdr_ok;
	logic [31:0]         frame_left;
	logic                frame_over;
	logic [31:0]         ents_left;
	logic [7:0]          comps_left;
	logic [31:0]         blob_left;
	logic [31:0]         evs_left;
	ftsp_pkg::out_item_t step_tok [2];
	int                  step_cnt;

	framed_trace_stream_parser_unit dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.byte_valid  (byte_valid),
		.byte_stall  (byte_stall),
		.byte_item   (byte_item),
		.token_valid (token_valid),
		.token_stall (token_stall),
		.token_item  (token_item),
		.psel        (psel),
		.penable     (penable),
		.pwrite      (pwrite),
		.paddr       (paddr),
		.pwdata      (pwdata),
		.prdata      (prdata),
		.pready      (pready)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// Reports the first few mismatches in full and counts the rest.
	function automatic void flag_mismatch(input string msg);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%s", msg);
		end
	endfunction

	// Puts the parser back at the start of a file.
	function automatic void restart_parser();
		prs_phase  = ftsp_pkg::PH_HDR;
		fld_idx    = '0;
		fld_acc    = '0;
		hdr_ok     = 2'b11;
		frame_left = '0;
		frame_over = 1'b0;
		ents_left  = '0;
		comps_left = '0;
		blob_left  = '0;
		evs_left   = '0;
	endfunction

	// A single input transaction yields at most two tokens.
	function automatic void add_token(input ftsp_pkg::tok_kind_t kind,
		input logic [63:0] value);
		if (step_cnt < 2) begin
			step_tok[step_cnt].token_kind  = kind;
			step_tok[step_cnt].token_value = value;
			step_tok[step_cnt].last_of_run = 1'b0;
			step_cnt++;
		end
	endfunction

	// An error token stops parsing until the end of the stream.
	function automatic void abort_file(input logic [63:0] code);
		add_token(ftsp_pkg::KIND_ERROR, code);
		prs_phase = ftsp_pkg::PH_STOP;
	endfunction

	// Gathers a little-endian field; returns 1 when its last byte is in.
	function automatic logic collect(input logic [7:0] b, input int width,
		output logic [63:0] v);
		fld_acc = fld_acc | (64'(b) << (8 * fld_idx[2:0]));
		fld_idx = fld_idx + 4'd1;
		v = fld_acc;
		if (fld_idx >= width) begin
			fld_acc = '0;
			fld_idx = '0;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// End of a frame body: drain the rest, flag an overrun, or close the frame.
	function automatic void close_body();
		if (frame_left != 0) begin
			prs_phase = ftsp_pkg::PH_DRAIN;
		end else if (frame_over) begin
			abort_file(ftsp_pkg::ERR_SIZE_DRIFT);
		end else begin
			add_token(ftsp_pkg::KIND_FRAME_OK, '0);
			prs_phase = ftsp_pkg::PH_FSIZE;
		end
	endfunction

	function automatic void close_event();
		evs_left--;
		if (evs_left == 0) begin
			close_body();
		end else begin
			prs_phase = ftsp_pkg::PH_EVLEN;
		end
	endfunction

	function automatic void close_entity();
		ents_left--;
		if (ents_left == 0) begin
			prs_phase = ftsp_pkg::PH_EVCOUNT;
		end else begin
			prs_phase = ftsp_pkg::PH_EIDX;
		end
	endfunction

	function automatic void close_component();
		comps_left--;
		if (comps_left == 0) begin
			close_entity();
		end else begin
			prs_phase = ftsp_pkg::PH_CTAG;
		end
	endfunction

	// Advances the predicted parser by one transaction and queues its tokens.
	function automatic void predict_tokens(input ftsp_pkg::in_item_t it);
		logic [63:0] v;
		logic [7:0]  b;
		step_cnt = 0;
		b = it.data_byte;
		if (it.req_type == ftsp_pkg::REQ_END) begin
			// End of stream reports where the file stopped, unless parsing had stopped on an error, then starts a new file.
			case (prs_phase)
				ftsp_pkg::PH_STOP: ;
				ftsp_pkg::PH_HDR: add_token(ftsp_pkg::KIND_ERROR, ftsp_pkg::ERR_SHORT_HEADER);
				ftsp_pkg::PH_FSIZE: begin
					if (fld_idx == 0) begin
						add_token(ftsp_pkg::KIND_FILE_OK, '0);
					end else begin
						add_token(ftsp_pkg::KIND_ERROR, ftsp_pkg::ERR_TRUNC_SIZE);
					end
				end
				default: begin
					if (frame_left != 0) begin
						add_token(ftsp_pkg::KIND_ERROR, ftsp_pkg::ERR_PAST_EOF);
					end else begin
						add_token(ftsp_pkg::KIND_ERROR, ftsp_pkg::ERR_TRUNC_BODY);
					end
				end
			endcase
			restart_parser();
		end else begin
			case (prs_phase)
				ftsp_pkg::PH_HDR: begin
					// Magic in bytes 0 to 3, version in bytes 4 and 5, rest skipped.
					if (fld_idx < 8) begin
						fld_acc = fld_acc | (64'(b) << (8 * fld_idx[2:0]));
					end
					if (fld_idx == 3 && fld_acc[31:0] != cfg_magic) begin
						hdr_ok[0] = 1'b0;
					end
					if (fld_idx == 5 && fld_acc[47:32] != cfg_version) begin
						hdr_ok[1] = 1'b0;
					end
					if (fld_idx >= ftsp_pkg::HeaderBytes - 1) begin
						fld_idx = '0;
						fld_acc = '0;
						if (!hdr_ok[0]) begin
							abort_file(ftsp_pkg::ERR_BAD_MAGIC);
						end else if (!hdr_ok[1]) begin
							abort_file(ftsp_pkg::ERR_BAD_VERSION);
						end else begin
							prs_phase = ftsp_pkg::PH_FSIZE;
						end
					end else begin
						fld_idx++;
					end
				end
				ftsp_pkg::PH_FSIZE: begin
					if (collect(b, 4, v)) begin
						frame_left = v[31:0];
						frame_over = 1'b0;
						prs_phase  = ftsp_pkg::PH_TICK;
					end
				end
				ftsp_pkg::PH_DRAIN: begin
					frame_left--;
					if (frame_left == 0) begin
						abort_file(ftsp_pkg::ERR_SIZE_DRIFT);
					end
				end
				ftsp_pkg::PH_STOP: ;
				default: begin
					// Body bytes use up the frame size; bytes past it mark an overrun.
					if (frame_left != 0) begin
						frame_left--;
					end else begin
						frame_over = 1'b1;
					end
					case (prs_phase)
						ftsp_pkg::PH_TICK: begin
							if (collect(b, 8, v)) begin
								add_token(ftsp_pkg::KIND_TICK, v);
								prs_phase = ftsp_pkg::PH_ECOUNT;
							end
						end
						ftsp_pkg::PH_ECOUNT: begin
							if (collect(b, 4, v)) begin
								add_token(ftsp_pkg::KIND_ENT_COUNT, v);
								ents_left = v[31:0];
								if (ents_left != 0) begin
									prs_phase = ftsp_pkg::PH_EIDX;
								end else begin
									prs_phase = ftsp_pkg::PH_EVCOUNT;
								end
							end
						end
						ftsp_pkg::PH_EIDX: begin
							if (collect(b, 4, v)) begin
								add_token(ftsp_pkg::KIND_INDEX, v);
								prs_phase = ftsp_pkg::PH_EGEN;
							end
						end
						ftsp_pkg::PH_EGEN: begin
							if (collect(b, 4, v)) begin
								add_token(ftsp_pkg::KIND_GEN, v);
								prs_phase = ftsp_pkg::PH_CCOUNT;
							end
						end
						ftsp_pkg::PH_CCOUNT: begin
							if (collect(b, 1, v)) begin
								add_token(ftsp_pkg::KIND_COMP_CNT, v);
								comps_left = v[7:0];
								if (comps_left == 0) begin
									close_entity();
								end else begin
									prs_phase = ftsp_pkg::PH_CTAG;
								end
							end
						end
						ftsp_pkg::PH_CTAG: begin
							if (collect(b, 2, v)) begin
								add_token(ftsp_pkg::KIND_TAG, v);
								prs_phase = ftsp_pkg::PH_CLEN;
							end
						end
						ftsp_pkg::PH_CLEN: begin
							if (collect(b, 2, v)) begin
								add_token(ftsp_pkg::KIND_PAY_LEN, v);
								blob_left = 32'(v[15:0]);
								if (blob_left == 0) begin
									close_component();
								end else begin
									prs_phase = ftsp_pkg::PH_CPAY;
								end
							end
						end
						ftsp_pkg::PH_CPAY: begin
							add_token(ftsp_pkg::KIND_PAY_BYTE, 64'(b));
							blob_left--;
							if (blob_left == 0) begin
								close_component();
							end
						end
						ftsp_pkg::PH_EVCOUNT: begin
							if (collect(b, 4, v)) begin
								add_token(ftsp_pkg::KIND_EV_COUNT, v);
								evs_left = v[31:0];
								if (evs_left == 0) begin
									close_body();
								end else begin
									prs_phase = ftsp_pkg::PH_EVLEN;
								end
							end
						end
						ftsp_pkg::PH_EVLEN: begin
							if (collect(b, 4, v)) begin
								add_token(ftsp_pkg::KIND_EV_LEN, v);
								blob_left = v[31:0];
								if (blob_left == 0) begin
									close_event();
								end else begin
									prs_phase = ftsp_pkg::PH_EVBYTES;
								end
							end
						end
						default: begin
							add_token(ftsp_pkg::KIND_EV_BYTE, 64'(b));
							blob_left--;
							if (blob_left == 0) begin
								close_event();
							end
						end
					endcase
				end
			endcase
		end
		for (int k = 0; k < step_cnt; k++) begin
			step_tok[k].last_of_run = (k == step_cnt - 1);
			tokens_due.insert(tokens_due.size(), step_tok[k]);
		end
	endfunction

	function automatic void queue_item(input logic req, input logic [7:0] data);
		ftsp_pkg::in_item_t it;
		it.req_type  = req;
		it.data_byte = data;
		pending_bytes.insert(pending_bytes.size(), it);
	endfunction

	// Appends an n-byte little-endian value to the file being built.
	function automatic void append_le(input logic [63:0] value, input int n);
		for (int k = 0; k < n; k++) begin
			trace_bytes.insert(trace_bytes.size(), value[8*k +: 8]);
		end
	endfunction

	// Builds one trace file, well formed or damaged in one of several ways, and queues it.
	function automatic void queue_file();
		int          mode;
		int          frames;
		int          drift_frame;
		int          start;
		int          body_len;
		int          drift;
		int          cut;
		int          count;
		int          comps;
		int          len;
		logic [31:0] magic;
		logic [15:0] version;
		logic [63:0] tick;
		mode = $urandom_range(0, 99);
		trace_bytes.delete();
		frame_starts.delete();
		cut = -1;
		magic = cfg_magic;
		version = cfg_version;
		if (mode >= 72 && mode < 80) begin
			len = $urandom_range(0, 3);
			magic[8*len +: 8] = magic[8*len +: 8] ^ 8'($urandom_range(1, 255));
		end else if (mode >= 80 && mode < 86) begin
			version = version ^ 16'($urandom_range(1, 65535));
		end
		append_le(magic, 4);
		append_le(version, 2);
		repeat (ftsp_pkg::HeaderBytes - 6) append_le($urandom, 1);
		if (mode >= 92) begin
			// Random bytes, after a good header or from the very start.
			if (mode >= 96) begin
				trace_bytes.delete();
			end
			repeat ($urandom_range(0, 40)) append_le($urandom, 1);
		end else begin
			if (mode >= 60 && mode < 72) begin
				frames = $urandom_range(1, 2);
			end else if (mode >= 72 && mode < 86) begin
				frames = $urandom_range(0, 1);
			end else begin
				frames = $urandom_range(0, 2);
			end
			drift_frame = (frames > 0) ? int'($urandom_range(0, frames - 1)) : 0;
			for (int f = 0; f < frames; f++) begin
				start = trace_bytes.size();
				frame_starts.insert(frame_starts.size(), start);
				append_le(0, 4);
				case ($urandom_range(0, 3))
					0: tick = '0;
					1: tick = '1;
					default: tick = {$urandom, $urandom};
				endcase
				append_le(tick, 8);
				count = $urandom_range(0, 2);
				append_le(count, 4);
				repeat (count) begin
					append_le($urandom, 4);
					append_le($urandom, 4);
					comps = $urandom_range(0, 2);
					append_le(comps, 1);
					repeat (comps) begin
						append_le($urandom, 2);
						len = $urandom_range(0, 3);
						append_le(len, 2);
						repeat (len) append_le($urandom, 1);
					end
				end
				count = $urandom_range(0, 2);
				append_le(count, 4);
				repeat (count) begin
					len = $urandom_range(0, 4);
					append_le(len, 4);
					repeat (len) append_le($urandom, 1);
				end
				// The frame size is patched in once the body length is known.
				body_len = trace_bytes.size() - start - 4;
				drift = 0;
				if (mode >= 60 && mode < 72 && f == drift_frame) begin
					drift = $urandom_range(1, 3);
					if ($urandom_range(0, 1) == 1) begin
						drift = -drift;
						// Sometimes end the stream in the body bytes past the frame's end.
						if ($urandom_range(0, 1) == 1) begin
							cut = start + 4 + body_len + drift + int'($urandom_range(0, -drift - 1));
						end
					end
				end
				for (int k = 0; k < 4; k++) begin
					trace_bytes[start + k] = 8'((body_len + drift) >> (8 * k));
				end
			end
		end
		if (mode >= 45 && mode < 60) begin
			// Truncate at a frame boundary, inside a size field, or anywhere.
			if (frame_starts.size() != 0 && $urandom_range(0, 1) == 1) begin
				cut = frame_starts[$urandom_range(0, frame_starts.size() - 1)]
					+ int'($urandom_range(0, 3));
			end else begin
				cut = $urandom_range(0, trace_bytes.size());
			end
		end else if (mode >= 86 && mode < 92) begin
			trace_bytes[$urandom_range(0, trace_bytes.size() - 1)] = 8'($urandom);
		end
		if (cut < 0 || cut > trace_bytes.size()) begin
			cut = trace_bytes.size();
		end
		for (int k = 0; k < cut; k++) begin
			queue_item(ftsp_pkg::REQ_BYTE, trace_bytes[k]);
		end
		queue_item(ftsp_pkg::REQ_END, 8'($urandom));
	endfunction

	// Waits until every queued transaction is taken and every token has arrived.
	task automatic settle();
		@(negedge clk);
		while (pending_bytes.size() != 0 || byte_valid || tokens_due.size() != 0) begin
			@(negedge clk);
		end
		repeat (DrainCycles) @(negedge clk);
	endtask

	// Writes a register, then reads it back.
	task automatic set_reg(input logic idx, input logic [31:0] value);
		logic [31:0] seen;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= ftsp_pkg::CfgAddrW'(4 * int'(idx));
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		if (idx == ftsp_pkg::REG_MAGIC) begin
			cfg_magic = value;
		end else begin
			cfg_version = value[15:0];
		end
		@(posedge clk);
		psel    <= 1'b1;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		seen = prdata;
		psel    <= 1'b0;
		penable <= 1'b0;
		if ((idx == ftsp_pkg::REG_MAGIC && seen != cfg_magic)
			|| (idx == ftsp_pkg::REG_VERSION && seen[15:0] != cfg_version)) begin
			flag_mismatch($sformatf("register %0d read back 0x%h after writing 0x%h",
				idx, seen, value));
		end
	endtask

	// Byte driver: a transaction is held until it is taken.
	always @(posedge clk) begin
		if (!arst_n) begin
			byte_valid <= 1'b0;
		end else if (!byte_valid || !byte_stall) begin
			if (byte_valid) begin
				predict_tokens(byte_item);
			end
			if (pending_bytes.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				byte_item  <= pending_bytes.pop_front();
				byte_valid <= 1'b1;
			end else begin
				byte_valid <= 1'b0;
			end
		end
	end

	// Token monitor: each taken transaction is checked against the oldest expectation.
	always @(posedge clk) begin
		if (arst_n && token_valid && !token_stall) begin
			tokens_seen++;
			if (tokens_due.size() == 0) begin
				flag_mismatch($sformatf("token %0d unexpected: kind %0d value 0x%h last %b",
					tokens_seen, token_item.token_kind, token_item.token_value,
					token_item.last_of_run));
			end else if (token_item.token_kind !== tokens_due[0].token_kind
				|| token_item.token_value !== tokens_due[0].token_value
				|| token_item.last_of_run !== tokens_due[0].last_of_run) begin
				flag_mismatch($sformatf(
					"token %0d: expected kind %0d value 0x%h last %b, got kind %0d value 0x%h last %b",
					tokens_seen, tokens_due[0].token_kind, tokens_due[0].token_value,
					tokens_due[0].last_of_run, token_item.token_kind, token_item.token_value,
					token_item.last_of_run));
				void'(tokens_due.pop_front());
			end else begin
				void'(tokens_due.pop_front());
			end
		end
		token_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	// Watchdog: too long without any transaction on either channel ends the run.
	always @(posedge clk) begin
		if (!arst_n || (byte_valid && !byte_stall) || (token_valid && !token_stall)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= QuietLimit) begin
			$display("Mismatches found");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin
		restart_parser();
		gap_pct = 27;
		stall_pct = 85;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: end of stream with no header, a header of all-ones bytes,
		// a byte dropped after the error, a silent restart, then a short header.
		queue_item(ftsp_pkg::REQ_END, 8'h00);
		repeat (ftsp_pkg::HeaderBytes) queue_item(ftsp_pkg::REQ_BYTE, 8'hFF);
		queue_item(ftsp_pkg::REQ_BYTE, 8'h00);
		queue_item(ftsp_pkg::REQ_END, 8'hFF);
		queue_item(ftsp_pkg::REQ_BYTE, ftsp_pkg::MagicReset[7:0]);
		queue_item(ftsp_pkg::REQ_BYTE, ftsp_pkg::MagicReset[15:8]);
		queue_item(ftsp_pkg::REQ_BYTE, ftsp_pkg::MagicReset[23:16]);
		queue_item(ftsp_pkg::REQ_END, 8'h5A);
		settle();

		// Random files with the register values after reset.
		while (pending_bytes.size() < 80) queue_file();
		settle();

		// Lowest register values.
		set_reg(ftsp_pkg::REG_MAGIC, 32'h0);
		set_reg(ftsp_pkg::REG_VERSION, 32'h0);
		while (pending_bytes.size() < 100) queue_file();
		settle();

		// Highest register values, with the idle pattern turned around.
		gap_pct = 85;
		stall_pct = 27;
		set_reg(ftsp_pkg::REG_MAGIC, 32'hFFFF_FFFF);
		set_reg(ftsp_pkg::REG_VERSION, 32'h0000_FFFF);
		while (pending_bytes.size() < 150) queue_file();
		settle();

		// Random register values at full rate on both sides.
		gap_pct = 0;
		stall_pct = 0;
		set_reg(ftsp_pkg::REG_MAGIC, $urandom);
		set_reg(ftsp_pkg::REG_VERSION, $urandom);
		while (pending_bytes.size() < 150) queue_file();
		settle();

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
